[rtl/i2cms_pkg.sv]
`default_nettype none
package i2cms_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_EVENT = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE           = 3'd0,
        ST_STARTED        = 3'd1,
        ST_RESTARTED      = 3'd2,
        ST_REPEATED_START = 3'd3,
        ST_DATA_ACK       = 3'd4,
        ST_DATA_NACK      = 3'd5
    } mstate_t;

    // controller status codes
    localparam logic [7:0] SC_START         = 8'h08;
    localparam logic [7:0] SC_RESTART       = 8'h10;
    localparam logic [7:0] SC_ADDR_ACK      = 8'h18;
    localparam logic [7:0] SC_ADDR_NACK     = 8'h20;
    localparam logic [7:0] SC_DATA_ACK      = 8'h28;
    localparam logic [7:0] SC_DATA_NACK     = 8'h30;
    localparam logic [7:0] SC_ARB_LOST      = 8'h38;
    localparam logic [7:0] SC_RD_ADDR_ACK   = 8'h40;
    localparam logic [7:0] SC_RD_ADDR_NACK  = 8'h48;
    localparam logic [7:0] SC_RX_ACK        = 8'h50;
    localparam logic [7:0] SC_RX_NACK       = 8'h58;

    // received bytes land from this buffer offset
    localparam logic [6:0] RX_OFFSET = 7'd3;

    // configuration register indexes (byte address / 4)
    localparam logic [1:0] CFG_WRITE_LENGTH = 2'd0;
    localparam logic [1:0] CFG_READ_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_RESTART_SKIP = 2'd2;

    // control flags of an item on its way to the output
    typedef struct packed {
        logic    tx_valid;
        logic    rd_sel;
        logic    byte_zero;
        logic    request_start;
        logic    request_stop;
        logic    request_ack;
        logic    clear_start;
        logic    clear_interrupt;
        mstate_t master_state;
    } stage_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       request_start;
        logic       request_stop;
        logic       request_ack;
        logic       clear_start;
        logic       clear_interrupt;
        logic [2:0] master_state;
        logic [7:0] read_data;
    } result_t;

endpackage
`default_nettype wire

[rtl/i2cms_if.sv]
`default_nettype none
interface i2cms_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [4:0] index;
    logic [7:0] data_byte;
    logic [7:0] status_code;

    modport source (output valid, output command, output index, output data_byte,
                    output status_code, input ready);
    modport sink (input valid, input command, input index, input data_byte,
                  input status_code, output ready);
endinterface

interface i2cms_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       request_start;
    logic       request_stop;
    logic       request_ack;
    logic       clear_start;
    logic       clear_interrupt;
    logic [2:0] master_state;
    logic [7:0] read_data;

    modport source (output valid, output tx_valid, output tx_byte,
                    output request_start, output request_stop, output request_ack,
                    output clear_start, output clear_interrupt, output master_state,
                    output read_data, input ready);
    modport sink (input valid, input tx_valid, input tx_byte,
                  input request_start, input request_stop, input request_ack,
                  input clear_start, input clear_interrupt, input master_state,
                  input read_data, output ready);
endinterface
`default_nettype wire

[rtl/i2c_master_status_sequencer.sv]
// I2C master status sequencer. Each item on item_in is one command: load a
// transfer-buffer byte, begin a transfer (positions cleared, state idle, start
// requested), feed one controller status event with the received data byte,
// or read a buffer byte back. Every item gives exactly one result item on
// item_out with the next transmit byte and the start/stop/ack/flag-clear
// requests for the controller, plus the master state after the item.
// Throughput is one item per clock while item_out is not stalled. On accept,
// stage 1 captures the synchronous buffer read and the control flags; stage 1
// then loads the output register, which drives item_out, once that is free.
// The buffer is a BUF_DEPTH x 8 memory with one write and one read
// port; positions and state live in flops and are updated in the accept cycle,
// so back-to-back events never see stale positions and no buffer forwarding
// is needed (an item whose read byte is used never writes the buffer). Each
// buffer entry has a valid bit cleared by reset, so the buffer reads as zero
// until written; no clearing pass is run. Buffer accesses at or past
// BUF_DEPTH read as zero and writes there are dropped. Configuration
// (write_length at 0x0, read_length at 0x4, restart_skips_write at 0x8) is an
// APB slave with pready tied high; write it only while the block is idle.
`default_nettype none
module i2c_master_status_sequencer #(
    parameter int BUF_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    i2cms_in_if.sink         item_in,
    i2cms_out_if.source      item_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    // extended buffer positions: up to 31 from index, 64 from write position, 66 from received offset
    localparam logic [8:0] DEPTH_EXT = 9'(BUF_DEPTH);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [5:0] wlen_reg;
    logic [4:0] rlen_reg;
    logic       skip_reg;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= '0;
            rlen_reg <= '0;
            skip_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                i2cms_pkg::CFG_WRITE_LENGTH: wlen_reg <= pwdata[5:0];
                i2cms_pkg::CFG_READ_LENGTH:  rlen_reg <= pwdata[4:0];
                i2cms_pkg::CFG_RESTART_SKIP: skip_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            i2cms_pkg::CFG_WRITE_LENGTH: prdata = {26'd0, wlen_reg};
            i2cms_pkg::CFG_READ_LENGTH:  prdata = {27'd0, rlen_reg};
            i2cms_pkg::CFG_RESTART_SKIP: prdata = {31'd0, skip_reg};
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: stage 1 (buffer read data) feeds the output register
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_move;
    logic accept;

    assign s1_move       = s1_valid_reg && (!out_valid_reg || item_out.ready);
    assign item_in.ready = !s1_valid_reg || s1_move;
    assign accept        = item_in.valid && item_in.ready;

    // ------------------------------------------------------------------
    // sequencer decode, done in the accept cycle
    // ------------------------------------------------------------------
    logic [5:0]          wpos_reg, wpos_next;
    logic [5:0]          rpos_reg, rpos_next;
    i2cms_pkg::mstate_t  st_reg, st_next;
    i2cms_pkg::stage_t   dec;
    logic [8:0]          rd_ext;
    logic [8:0]          wr_ext;
    logic                wr_en;
    logic [5:0]          wpos_inc;
    logic [5:0]          rpos_inc;

    assign wpos_inc = wpos_reg + 6'd1;
    assign rpos_inc = rpos_reg + 6'd1;

    always_comb
    begin
        wpos_next = wpos_reg;
        rpos_next = rpos_reg;
        st_next   = st_reg;
        dec       = '0;
        rd_ext    = {3'd0, wpos_reg};
        wr_ext    = {4'd0, item_in.index};
        wr_en     = 1'b0;
        case (i2cms_pkg::cmd_t'(item_in.command))
            i2cms_pkg::CMD_LOAD:
            begin
                wr_en = 1'b1;
            end
            i2cms_pkg::CMD_BEGIN:
            begin
                st_next           = i2cms_pkg::ST_IDLE;
                wpos_next         = '0;
                rpos_next         = '0;
                dec.request_start = 1'b1;
            end
            i2cms_pkg::CMD_READ:
            begin
                dec.rd_sel = 1'b1;
                rd_ext     = {4'd0, item_in.index};
            end
            i2cms_pkg::CMD_EVENT:
            begin
                dec.clear_interrupt = 1'b1;
                case (item_in.status_code)
                    i2cms_pkg::SC_START:
                    begin
                        dec.tx_valid    = 1'b1;
                        wpos_next       = wpos_inc;
                        dec.clear_start = 1'b1;
                        st_next         = i2cms_pkg::ST_STARTED;
                    end
                    i2cms_pkg::SC_RESTART:
                    begin
                        if (!skip_reg)
                        begin
                            dec.tx_valid = 1'b1;
                            wpos_next    = wpos_inc;
                        end
                        dec.clear_start = 1'b1;
                        st_next         = i2cms_pkg::ST_RESTARTED;
                    end
                    i2cms_pkg::SC_ADDR_ACK:
                    begin
                        if (st_reg == i2cms_pkg::ST_STARTED)
                        begin
                            dec.tx_valid = 1'b1;
                            wpos_next    = wpos_inc;
                            st_next      = i2cms_pkg::ST_DATA_ACK;
                        end
                    end
                    i2cms_pkg::SC_DATA_ACK:
                    begin
                        if (wpos_reg < wlen_reg)
                        begin
                            dec.tx_valid = 1'b1;
                            wpos_next    = wpos_inc;
                        end
                        else if (rlen_reg != 5'd0)
                        begin
                            dec.request_start = 1'b1;
                        end
                        else
                        begin
                            dec.request_stop = 1'b1;
                            st_next          = i2cms_pkg::ST_IDLE;
                        end
                    end
                    i2cms_pkg::SC_DATA_NACK:
                    begin
                        if (wpos_reg != wlen_reg)
                        begin
                            // one past the current position, without wrap
                            dec.tx_valid = 1'b1;
                            rd_ext       = {3'd0, wpos_reg} + 9'd1;
                            wpos_next    = wpos_inc;
                            if (wpos_inc != wlen_reg)
                            begin
                                st_next = i2cms_pkg::ST_DATA_ACK;
                            end
                            else if (rlen_reg != 5'd0)
                            begin
                                dec.request_start = 1'b1;
                                st_next           = i2cms_pkg::ST_REPEATED_START;
                            end
                            else
                            begin
                                st_next = i2cms_pkg::ST_DATA_NACK;
                            end
                        end
                        else if (rlen_reg != 5'd0)
                        begin
                            dec.request_start = 1'b1;
                            st_next           = i2cms_pkg::ST_REPEATED_START;
                        end
                        else
                        begin
                            dec.request_stop = 1'b1;
                            st_next          = i2cms_pkg::ST_DATA_NACK;
                        end
                    end
                    i2cms_pkg::SC_RD_ADDR_ACK:
                    begin
                        dec.request_ack = 1'b1;
                    end
                    i2cms_pkg::SC_RX_ACK,
                    i2cms_pkg::SC_RX_NACK:
                    begin
                        wr_en  = 1'b1;
                        wr_ext = {2'd0, 7'({1'b0, rpos_reg} + i2cms_pkg::RX_OFFSET)};
                        if (rpos_inc != {1'b0, rlen_reg})
                        begin
                            rpos_next = rpos_inc;
                            st_next   = i2cms_pkg::ST_DATA_ACK;
                        end
                        else
                        begin
                            rpos_next = '0;
                            st_next   = i2cms_pkg::ST_DATA_NACK;
                        end
                        dec.request_ack = 1'b1;
                    end
                    i2cms_pkg::SC_ADDR_NACK,
                    i2cms_pkg::SC_RD_ADDR_NACK:
                    begin
                        st_next = i2cms_pkg::ST_DATA_NACK;
                    end
                    // arbitration lost and anything else: interrupt clear only
                    i2cms_pkg::SC_ARB_LOST: ;
                    default: ;
                endcase
            end
            default: ;
        endcase
        dec.master_state = st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= '0;
            rpos_reg <= '0;
            st_reg   <= i2cms_pkg::ST_IDLE;
        end
        else if (accept)
        begin
            wpos_reg <= wpos_next;
            rpos_reg <= rpos_next;
            st_reg   <= st_next;
        end
    end

    // ------------------------------------------------------------------
    // transfer buffer: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [7:0]           buf_mem [BUF_DEPTH];
    logic [BUF_DEPTH-1:0] buf_valid_reg;
    logic [7:0]           rdata_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 rd_in_range;
    logic                 wr_hit;

    assign rd_addr     = rd_ext[AW-1:0];
    assign wr_addr     = wr_ext[AW-1:0];
    assign rd_in_range = rd_ext < DEPTH_EXT;
    assign wr_hit      = accept && wr_en && (wr_ext < DEPTH_EXT);

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            buf_mem[wr_addr] <= item_in.data_byte;
        end
        if (accept)
        begin
            rdata_reg <= buf_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= '0;
        end
        else if (wr_hit)
        begin
            buf_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stage 1 and output register
    // ------------------------------------------------------------------
    i2cms_pkg::stage_t  s1_reg;
    i2cms_pkg::stage_t  s1_next;
    i2cms_pkg::result_t out_reg;
    i2cms_pkg::result_t res_next;
    logic [7:0]         s1_byte;

    always_comb
    begin
        s1_next           = dec;
        // out of range or never written reads as zero
        s1_next.byte_zero = !rd_in_range || !buf_valid_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_move)
        begin
            out_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (item_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s1_byte = s1_reg.byte_zero ? 8'd0 : rdata_reg;

    always_comb
    begin
        res_next.tx_valid        = s1_reg.tx_valid;
        res_next.tx_byte         = s1_reg.tx_valid ? s1_byte : 8'd0;
        res_next.request_start   = s1_reg.request_start;
        res_next.request_stop    = s1_reg.request_stop;
        res_next.request_ack     = s1_reg.request_ack;
        res_next.clear_start     = s1_reg.clear_start;
        res_next.clear_interrupt = s1_reg.clear_interrupt;
        res_next.master_state    = s1_reg.master_state;
        res_next.read_data       = s1_reg.rd_sel ? s1_byte : 8'd0;
    end

    assign item_out.valid           = out_valid_reg;
    assign item_out.tx_valid        = out_reg.tx_valid;
    assign item_out.tx_byte         = out_reg.tx_byte;
    assign item_out.request_start   = out_reg.request_start;
    assign item_out.request_stop    = out_reg.request_stop;
    assign item_out.request_ack     = out_reg.request_ack;
    assign item_out.clear_start     = out_reg.clear_start;
    assign item_out.clear_interrupt = out_reg.clear_interrupt;
    assign item_out.master_state    = out_reg.master_state;
    assign item_out.read_data       = out_reg.read_data;

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import i2cms_pkg::*;

    // ------------------------------------------------------------------
    // Predictor and result checker. Keeps its own copy of the transfer
    // buffer, positions, master state and registers. Every accepted
    // command produces exactly one expected result item.
    // ------------------------------------------------------------------
    class status_sequencer_check;
        logic [7:0] xfer_bytes [32];
        logic [5:0] wr_pos;
        logic [5:0] rd_pos;
        mstate_t    state;
        logic [5:0] wr_len;
        logic [4:0] rd_len;
        logic       skip_restart_tx;
        result_t    pending_results [$];
        int         mismatches;
        int         results_seen;

        function new();
            foreach (xfer_bytes[i]) xfer_bytes[i] = 8'h00;
            wr_pos = '0;
            rd_pos = '0;
            state = ST_IDLE;
            wr_len = '0;
            rd_len = '0;
            skip_restart_tx = 1'b0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        // positions at or past the buffer depth read zero
        function logic [7:0] fetch(int unsigned pos);
            if (pos < 32) return xfer_bytes[pos];
            return 8'h00;
        endfunction

        // and writes there are dropped
        function void store(int unsigned pos, logic [7:0] v);
            if (pos < 32) xfer_bytes[pos] = v;
        endfunction

        function void set_reg(logic [1:0] reg_idx, logic [31:0] value);
            case (reg_idx)
                CFG_WRITE_LENGTH: wr_len = value[5:0];
                CFG_READ_LENGTH:  rd_len = value[4:0];
                CFG_RESTART_SKIP: skip_restart_tx = value[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void send_byte(ref result_t r, input int unsigned pos);
            r.tx_valid = 1'b1;
            r.tx_byte = fetch(pos);
        endfunction

        function void accept_command(cmd_t cmd, logic [4:0] idx, logic [7:0] dat,
                                     logic [7:0] stat);
            result_t r;
            r = '0;
            case (cmd)
                CMD_LOAD: store(idx, dat);
                CMD_BEGIN:
                begin
                    state = ST_IDLE;
                    rd_pos = '0;
                    wr_pos = '0;
                    r.request_start = 1'b1;
                end
                CMD_READ: r.read_data = fetch(idx);
                default:
                begin
                    r.clear_interrupt = 1'b1;
                    case (stat)
                        SC_START:
                        begin
                            send_byte(r, wr_pos);
                            wr_pos = wr_pos + 6'd1;
                            r.clear_start = 1'b1;
                            state = ST_STARTED;
                        end
                        SC_RESTART:
                        begin
                            if (!skip_restart_tx)
                            begin
                                send_byte(r, wr_pos);
                                wr_pos = wr_pos + 6'd1;
                            end
                            r.clear_start = 1'b1;
                            state = ST_RESTARTED;
                        end
                        SC_ADDR_ACK:
                        begin
                            if (state == ST_STARTED)
                            begin
                                send_byte(r, wr_pos);
                                wr_pos = wr_pos + 6'd1;
                                state = ST_DATA_ACK;
                            end
                        end
                        SC_DATA_ACK:
                        begin
                            if (wr_pos < wr_len)
                            begin
                                send_byte(r, wr_pos);
                                wr_pos = wr_pos + 6'd1;
                            end
                            else if (rd_len != 0)
                                r.request_start = 1'b1;
                            else
                            begin
                                r.request_stop = 1'b1;
                                state = ST_IDLE;
                            end
                        end
                        SC_DATA_NACK:
                        begin
                            if (wr_pos != wr_len)
                            begin
                                // byte after the current position goes out
                                send_byte(r, int'(wr_pos) + 1);
                                wr_pos = wr_pos + 6'd1;
                                if (wr_pos != wr_len)
                                    state = ST_DATA_ACK;
                                else if (rd_len != 0)
                                begin
                                    r.request_start = 1'b1;
                                    state = ST_REPEATED_START;
                                end
                                else
                                    state = ST_DATA_NACK;
                            end
                            else if (rd_len != 0)
                            begin
                                r.request_start = 1'b1;
                                state = ST_REPEATED_START;
                            end
                            else
                            begin
                                r.request_stop = 1'b1;
                                state = ST_DATA_NACK;
                            end
                        end
                        SC_RD_ADDR_ACK: r.request_ack = 1'b1;
                        SC_RX_ACK, SC_RX_NACK:
                        begin
                            store(3 + int'(rd_pos), dat);
                            rd_pos = rd_pos + 6'd1;
                            if (rd_pos != {1'b0, rd_len})
                                state = ST_DATA_ACK;
                            else
                            begin
                                rd_pos = '0;
                                state = ST_DATA_NACK;
                            end
                            r.request_ack = 1'b1;
                        end
                        SC_ADDR_NACK, SC_RD_ADDR_NACK: state = ST_DATA_NACK;
                        default: ;
                    endcase
                end
            endcase
            r.master_state = state;
            pending_results.push_back(r);
        endfunction

        function void cmp(string field, logic [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected %02h, got %02h",
                             results_seen, field, exp_v, act_v);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: no result expected, got %h", results_seen, got);
                return;
            end
            want = pending_results.pop_front();
            cmp("tx_valid", want.tx_valid, got.tx_valid);
            cmp("tx_byte", want.tx_byte, got.tx_byte);
            cmp("request_start", want.request_start, got.request_start);
            cmp("request_stop", want.request_stop, got.request_stop);
            cmp("request_ack", want.request_ack, got.request_ack);
            cmp("clear_start", want.clear_start, got.clear_start);
            cmp("clear_interrupt", want.clear_interrupt, got.clear_interrupt);
            cmp("master_state", want.master_state, got.master_state);
            cmp("read_data", want.read_data, got.read_data);
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          ITEMS_PER_PHASE = 220;
    localparam int          HOLD_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    i2cms_in_if  in_if ();
    i2cms_out_if out_if ();

    i2c_master_status_sequencer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (in_if.sink),
        .item_out (out_if.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    status_sequencer_check sb = new();

    // idle percentages per phase, and receiver hold-off requests
    int send_idle_pct = 0;
    int rx_stall_pct = 0;
    int holds_asked = 0;
    int items_sent = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog: one cycle counter for the whole run
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: ready changes on the falling edge. A pending hold-off
    // request holds ready low for the hold-off, otherwise random stalls.
    initial
    begin : rx_driver
        int holds_done;
        int hold_left;
        holds_done = 0;
        hold_left = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready = 1'b0;
            end
            else
                out_if.ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got.tx_valid        = out_if.tx_valid;
            got.tx_byte         = out_if.tx_byte;
            got.request_start   = out_if.request_start;
            got.request_stop    = out_if.request_stop;
            got.request_ack     = out_if.request_ack;
            got.clear_start     = out_if.clear_start;
            got.clear_interrupt = out_if.clear_interrupt;
            got.master_state    = out_if.master_state;
            got.read_data       = out_if.read_data;
            sb.check_result(got);
        end
    end

    // Offer one command; valid stays high into the next call unless the
    // random gap lowers it.
    task automatic send_item(cmd_t cmd, logic [4:0] idx, logic [7:0] dat, logic [7:0] stat);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_if.valid = 1'b0;
            @(negedge clk);
        end
        in_if.valid       = 1'b1;
        in_if.command     = cmd;
        in_if.index       = idx;
        in_if.data_byte   = dat;
        in_if.status_code = stat;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.accept_command(cmd, idx, dat, stat);
        items_sent++;
    endtask

    function automatic logic [7:0] any_status();
        case ($urandom_range(12))
            0:  return SC_START;
            1:  return SC_RESTART;
            2:  return SC_ADDR_ACK;
            3:  return SC_ADDR_NACK;
            4:  return SC_DATA_ACK;
            5:  return SC_DATA_NACK;
            6:  return SC_ARB_LOST;
            7:  return SC_RD_ADDR_ACK;
            8:  return SC_RD_ADDR_NACK;
            9:  return SC_RX_ACK;
            10: return SC_RX_NACK;
            default: return 8'($urandom);
        endcase
    endfunction

    // status event with random data; a few get a wrong code (broken sequence)
    task automatic send_event(logic [7:0] stat);
        if ($urandom_range(99) < 4)
            stat = any_status();
        send_item(CMD_EVENT, 5'($urandom), 8'($urandom), stat);
    endtask

    task automatic send_noise();
        send_item(cmd_t'($urandom_range(3)), 5'($urandom), 8'($urandom), any_status());
    endtask

    // Long event run without begin, so the 6-bit positions wrap.
    task automatic wrap_run();
        logic [7:0] stat;
        case ($urandom_range(2))
            0:       stat = SC_START;
            1:       stat = SC_DATA_NACK;
            default: stat = SC_RX_ACK;
        endcase
        repeat ($urandom_range(66, 72))
            send_item(CMD_EVENT, 5'($urandom), 8'($urandom), stat);
    endtask

    // One well-formed transfer: loads, begin, address and data bytes, then an
    // optional read phase after the repeated start, and a few read-backs.
    task automatic run_transfer(int wl, int rl);
        int sent;
        repeat ($urandom_range(0, 3))
            send_item(CMD_LOAD, 5'($urandom), 8'($urandom), 8'($urandom));
        send_item(CMD_BEGIN, 5'($urandom), 8'($urandom), 8'($urandom));
        send_event(SC_START);
        send_event(SC_ADDR_ACK);
        for (sent = 2; sent < wl; sent++)
            send_event(($urandom_range(9) == 0) ? SC_DATA_NACK : SC_DATA_ACK);
        send_event(SC_DATA_ACK);
        if (rl != 0)
        begin
            send_event(SC_RESTART);
            if ($urandom_range(9) == 0)
            begin
                send_event(SC_RD_ADDR_NACK);
                return;
            end
            send_event(SC_RD_ADDR_ACK);
            repeat (rl - 1)
                send_event(SC_RX_ACK);
            send_event(SC_RX_NACK);
        end
        repeat ($urandom_range(0, 2))
            send_item(CMD_READ, 5'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // APB write: setup, then access; register takes the value at the
    // access edge
    task automatic write_reg(logic [1:0] reg_idx, logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(reg_idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_regs(int wl, int rl, int skip);
        write_reg(CFG_WRITE_LENGTH, 32'(wl));
        write_reg(CFG_READ_LENGTH, 32'(rl));
        write_reg(CFG_RESTART_SKIP, 32'(skip));
    endtask

    // stop offering, wait for every result, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        in_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : main
        int wl;
        int rl;
        int skip;
        int target;
        int roll;

        in_if.valid       = 1'b0;
        in_if.command     = CMD_LOAD;
        in_if.index       = '0;
        in_if.data_byte   = '0;
        in_if.status_code = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---------------- directed part ----------------
        set_regs(4, 2, 0);
        // untouched buffer reads zero at both ends
        send_item(CMD_READ, 5'd0, 8'h00, 8'h00);
        send_item(CMD_READ, 5'd31, 8'hFF, 8'hFF);
        send_item(CMD_LOAD, 5'd0, 8'hA0, 8'h00);
        send_item(CMD_LOAD, 5'd1, 8'h12, 8'h00);
        send_item(CMD_LOAD, 5'd2, 8'hFF, 8'h00);
        send_item(CMD_LOAD, 5'd31, 8'h5A, 8'hFF);
        send_item(CMD_READ, 5'd31, 8'h00, 8'h00);
        // full write-then-read transfer
        send_item(CMD_BEGIN, 5'd0, 8'h00, 8'h00);
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_START);
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_ADDR_ACK);
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_DATA_ACK);
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_DATA_ACK);
        // all bytes out, read pending: start requested
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_DATA_ACK);
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_RESTART);
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_RD_ADDR_ACK);
        send_item(CMD_EVENT, 5'd0, 8'h11, SC_RX_ACK);
        // last byte received: read position back to zero
        send_item(CMD_EVENT, 5'd31, 8'hEE, SC_RX_NACK);
        send_item(CMD_READ, 5'd3, 8'h00, 8'h00);
        send_item(CMD_READ, 5'd4, 8'h00, 8'h00);
        // data nack with bytes left sends the next byte over
        send_item(CMD_BEGIN, 5'd0, 8'h00, 8'h00);
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_START);
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_DATA_NACK);
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_ADDR_NACK);
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_RD_ADDR_NACK);
        // arbitration lost and unknown codes only clear the interrupt
        send_item(CMD_EVENT, 5'd0, 8'h00, SC_ARB_LOST);
        send_item(CMD_EVENT, 5'd0, 8'h00, 8'hFF);
        send_item(CMD_EVENT, 5'd0, 8'h00, 8'h00);

        // ---------------- random phases ----------------
        // idle mode follows phase mod 4: none, sender, receiver, both
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    wl = 32; rl = 29; skip = 0;
                end
                1:
                begin
                    wl = 0; rl = 0; skip = 1;
                end
                7:
                begin
                    wl = 32; rl = 0; skip = 1;
                end
                default:
                begin
                    wl = $urandom_range(0, 8);
                    rl = $urandom_range(0, 5);
                    skip = $urandom_range(1);
                end
            endcase
            set_regs(wl, rl, skip);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0; rx_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 83; rx_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0; rx_stall_pct = 83;
                end
                default:
                begin
                    send_idle_pct = 6; rx_stall_pct = 6;
                end
            endcase
            // long receiver hold-off while items keep coming: block backs up
            if (ph == 4)
                holds_asked++;
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    run_transfer(wl, rl);
                else if (roll < 73)
                    wrap_run();
                else
                    repeat ($urandom_range(1, 6)) send_noise();
            end
        end
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
